@@ hdl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define PCAH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define PCAH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pcah_pkg.sv @@
// Package: sizes, item codes and shared types of the per-channel ADC histogram.
`timescale 1ns / 1ps

package pcah_pkg;

    localparam int ADC_BITS    = 12;
    localparam int BOARD_COUNT = 8;
    localparam int COUNT_BITS  = 32;

    // fixed widths of the item fields
    localparam int KIND_W    = 2;
    localparam int BOARD_W   = 3;
    localparam int CODE_W    = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam int CODE_RANGE  = 1 << ADC_BITS;
    localparam int BOARD_IDX_W = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
    localparam int ADDR_W      = BOARD_IDX_W + ADC_BITS;
    localparam int STORE_DEPTH = BOARD_COUNT * CODE_RANGE;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    typedef logic [BOARD_COUNT-1:0] board_mask_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    // classified item as it sits in the queue
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              board_ok;
        logic              code_ok;
        board_mask_t       board_bit;
        addr_t             addr;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

endpackage

@@ hdl/pcah_front.sv @@
// Front end: accepts items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps

module pcah_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcah_pkg::S_TDATA_W-1:0]  s_tdata,  // [2:0] board, [14:3] adc_code
    input  logic [pcah_pkg::KIND_W-1:0]     s_tuser,  // [1:0] kind
    input  pcah_pkg::back_stat_t            back_stat,
    output pcah_pkg::queue_head_t           head
);

    pcah_pkg::op_t                  queue_reg [pcah_pkg::QUEUE_DEPTH];
    logic [pcah_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pcah_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pcah_pkg::QPTR_W:0]      fill_reg, fill_next;

    logic [pcah_pkg::BOARD_W-1:0]   board;
    logic [pcah_pkg::CODE_W-1:0]    code;
    pcah_pkg::op_t                  new_op;
    logic                           push;
    logic                           pop;
    logic                           full;

    assign board = s_tdata[pcah_pkg::BOARD_W-1:0];
    assign code  = s_tdata[pcah_pkg::BOARD_W +: pcah_pkg::CODE_W];

    always_comb begin
        new_op.kind     = s_tuser;
        new_op.board_ok = 32'(board) < 32'(pcah_pkg::BOARD_COUNT);
        new_op.code_ok  = 32'(code) < 32'(pcah_pkg::CODE_RANGE);
        new_op.board_bit = new_op.board_ok ?
            (pcah_pkg::board_mask_t'(1) << board) : '0;
        new_op.addr = {pcah_pkg::BOARD_IDX_W'(board), pcah_pkg::ADC_BITS'(code)};
    end

    assign full     = fill_reg == (pcah_pkg::QPTR_W + 1)'(pcah_pkg::QUEUE_DEPTH);
    assign s_tready = !full && !back_stat.clearing;
    // unused kind is taken and dropped here
    assign push     = s_tvalid && s_tready && (s_tuser != pcah_pkg::KIND_UNUSED);
    assign pop      = back_stat.pop && (fill_reg != '0);

    assign head.valid = fill_reg != '0;
    assign head.op    = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule

@@ hdl/pcah_back.sv @@
// Back end: bin store with clearing pass, read-modify-write and result register.
`timescale 1ns / 1ps

module pcah_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pcah_pkg::queue_head_t           head,
    output pcah_pkg::back_stat_t            back_stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcah_pkg::M_TDATA_W-1:0]  m_tdata,  // [31:0] count
    output logic [0:0]                      m_tuser   // [0] board_used
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_FETCH = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    pcah_pkg::addr_t                clr_addr_reg, clr_addr_next;
    pcah_pkg::op_t                  op_reg;
    pcah_pkg::count_t               rd_data_reg;
    pcah_pkg::board_mask_t          used_reg, used_next;
    pcah_pkg::board_mask_t          seen_reg, seen_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pcah_pkg::M_TDATA_W-1:0] out_count_reg;
    logic                           out_used_reg;

    pcah_pkg::count_t               store [pcah_pkg::STORE_DEPTH];

    logic                           rd_en;
    logic                           wr_en;
    pcah_pkg::addr_t                wr_addr;
    pcah_pkg::count_t               wr_data;
    logic                           load_out;
    pcah_pkg::count_t               fill_value;
    logic                           board_used;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_used_reg;

    assign back_stat.clearing = state_reg == ST_CLEAR;
    assign back_stat.pop      = (state_reg == ST_FETCH) && head.valid;
    assign rd_en              = back_stat.pop;

    assign board_used = |(used_reg & op_reg.board_bit);

    // fill rule: once a board showed a nonzero bin, its empty bins read as 1
    always_comb begin
        fill_value = '0;
        if (op_reg.board_ok && op_reg.code_ok) begin
            if (rd_data_reg != '0) begin
                fill_value = rd_data_reg;
            end else if (|(seen_reg & op_reg.board_bit)) begin
                fill_value = pcah_pkg::count_t'(1);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        used_next      = used_reg;
        seen_next      = seen_reg;
        wr_en          = 1'b0;
        wr_addr        = op_reg.addr;
        wr_data        = rd_data_reg + 1'b1;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == pcah_pkg::ADDR_W'(pcah_pkg::STORE_DEPTH - 1)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (head.valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (op_reg.kind)
                    pcah_pkg::KIND_SAMPLE: begin
                        used_next  = used_reg | op_reg.board_bit;
                        wr_en      = op_reg.board_ok && op_reg.code_ok
                                     && (rd_data_reg != '1);
                        state_next = ST_FETCH;
                    end
                    pcah_pkg::KIND_RESTART: begin
                        seen_next  = '0;
                        state_next = ST_FETCH;
                    end
                    pcah_pkg::KIND_READ: begin
                        if (!out_valid_reg || m_tready) begin
                            load_out       = 1'b1;
                            out_valid_next = 1'b1;
                            if (op_reg.code_ok && (rd_data_reg != '0)) begin
                                seen_next = seen_reg | op_reg.board_bit;
                            end
                            state_next = ST_FETCH;
                        end
                    end
                    default: begin
                        state_next = ST_FETCH;
                    end
                endcase
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            used_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            used_reg      <= used_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            op_reg <= head.op;
        end
        if (load_out) begin
            out_count_reg <= pcah_pkg::M_TDATA_W'(64'(fill_value));
            out_used_reg  <= board_used;
        end
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store[head.op.addr];
        end
    end

endmodule

@@ hdl/per_channel_adc_histogram_core.sv @@
// Top level of the per-channel ADC histogram.
`timescale 1ns / 1ps

// Keeps a histogram of ADC codes for each of BOARD_COUNT boards, 2^ADC_BITS bins of
// COUNT_BITS each, in one single-port-write memory. Input items carry kind in tuser
// (0 sample, 1 read, 2 restart readout flags, 3 ignored). A sample bumps its bin
// (saturating) and marks the board used; a read returns one bin through the fill rule
// plus the board's used bit; a restart clears the readout flags. Out-of-range boards
// or codes read as zero. The front end accepts one item per cycle into a 4-entry
// queue unless full or clearing; the back end takes each queued item through a
// registered memory read, then the update or the result (which may wait on
// m_tready), and only then takes the next, so the bin read-modify-write sets the
// rate. After reset the memory is swept to zero, one bin per cycle, s_tready low.
module per_channel_adc_histogram_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcah_pkg::S_TDATA_W-1:0]  s_tdata,  // [2:0] board, [14:3] adc_code
    input  logic [pcah_pkg::KIND_W-1:0]     s_tuser,  // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcah_pkg::M_TDATA_W-1:0]  m_tdata,  // [31:0] count
    output logic [0:0]                      m_tuser   // [0] board_used
);

    pcah_pkg::queue_head_t head;
    pcah_pkg::back_stat_t  back_stat;

    pcah_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .back_stat (back_stat),
        .head      (head)
    );

    pcah_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .back_stat (back_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hdl/pcah_checker.sv @@
// Port-level checker for the histogram core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcah_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pcah_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [pcah_pkg::KIND_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcah_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser
);

    logic s_seen;
    assign s_seen = s_tvalid || (s_tdata != '0) || (s_tuser != '0);

    // a stalled result keeps its value
    `PCAH_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

    // a board with no samples has only empty bins, and the fill rule never lifts them
    `PCAH_ASSERT(a_unused_zero, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "nonzero count for unused board")

    // the clearing pass keeps the input closed right after reset
    `PCAH_ASSERT_ALWAYS(a_clear_blocks, aclk, (!aresetn || (!aresetn && s_seen)) |=> !s_tready, "input open during clearing")

    // reset drops any pending result
    `PCAH_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind per_channel_adc_histogram_core pcah_checker u_pcah_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
